[hw/rtl/lav_pkg.sv]
// Shared constants and types for the look-at view matrix block.
`default_nettype none
package lav_pkg;
    localparam int FRAC_BITS = 16;
    localparam int IN_W      = 32;
    localparam int D_W       = IN_W + 1;
    localparam int AX_W      = FRAC_BITS + 2;
    localparam int V_W       = FRAC_BITS + 35;
    localparam int MAG_W     = 31;
    localparam int SQ_W      = 62;
    localparam int NUM_W     = FRAC_BITS + 32;
    localparam int DOT_W     = FRAC_BITS + 36;
    localparam int DCNT_W    = $clog2(FRAC_BITS + 1);
    localparam logic [V_W-1:0] PRE_LIM = V_W'(64'd1 << 30);

    typedef struct packed {
        logic [2:0][IN_W-1:0] eye;
        logic [2:0][D_W-1:0]  dif;
        logic [2:0][IN_W-1:0] up;
    } t_item;

    typedef struct packed {
        logic done;
        logic ok;
    } t_norm_res;
endpackage
`default_nettype wire

[hw/rtl/look_at_view_matrix.sv]
// Top level of the look-at view matrix block.
//
//  channel | valid   | ready   | payload
//  --------+---------+---------+---------------------------------------------
//  input   | i_valid | o_ready | i_eye_*, i_target_*, i_up_*
//  output  | o_valid | i_ready | o_row_index, o_entry_a/b/c, o_shift_term,
//          |         |         | o_last_row, o_degenerate
//
// One request gives three rows; the shared normalize unit sets the pace (31-step square
// root, a load and serial divide per component, prescale shifts per vector, three
// vectors in turn; load and divide are skipped for a zero vector), plus cross, dot
// and emit steps.
// Reset is synchronous, active low; the queue and output register come up empty.
// The front and a two-entry queue keep taking requests while the back end works;
// while the output register holds a row until i_ready, the back end waits at its emit step.
`default_nettype none
module look_at_view_matrix import lav_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic signed [IN_W-1:0] i_eye_x,
    input  wire logic signed [IN_W-1:0] i_eye_y,
    input  wire logic signed [IN_W-1:0] i_eye_z,
    input  wire logic signed [IN_W-1:0] i_target_x,
    input  wire logic signed [IN_W-1:0] i_target_y,
    input  wire logic signed [IN_W-1:0] i_target_z,
    input  wire logic signed [IN_W-1:0] i_up_x,
    input  wire logic signed [IN_W-1:0] i_up_y,
    input  wire logic signed [IN_W-1:0] i_up_z,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [1:0]                  o_row_index,
    output logic signed [AX_W-1:0]      o_entry_a,
    output logic signed [AX_W-1:0]      o_entry_b,
    output logic signed [AX_W-1:0]      o_entry_c,
    output logic signed [IN_W-1:0]      o_shift_term,
    output logic                        o_last_row,
    output logic                        o_degenerate
);
    logic  c_fr_valid, c_fr_ready, c_q_valid, c_q_ready;
    t_item c_fr_item, c_q_item;
    logic [2:0][IN_W-1:0] c_eye, c_target, c_up;

    assign c_eye    = {i_eye_z, i_eye_y, i_eye_x};
    assign c_target = {i_target_z, i_target_y, i_target_x};
    assign c_up     = {i_up_z, i_up_y, i_up_x};

    lav_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_eye    (c_eye),
        .i_target (c_target),
        .i_up     (c_up),
        .o_valid  (c_fr_valid),
        .i_ready  (c_fr_ready),
        .o_item   (c_fr_item)
    );

    lav_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (c_fr_valid),
        .o_ready (c_fr_ready),
        .i_item  (c_fr_item),
        .o_valid (c_q_valid),
        .i_ready (c_q_ready),
        .o_item  (c_q_item)
    );

    lav_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (c_q_valid),
        .o_ready      (c_q_ready),
        .i_item       (c_q_item),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_row_index  (o_row_index),
        .o_entry_a    (o_entry_a),
        .o_entry_b    (o_entry_b),
        .o_entry_c    (o_entry_c),
        .o_shift_term (o_shift_term),
        .o_last_row   (o_last_row),
        .o_degenerate (o_degenerate)
    );
endmodule
`default_nettype wire

[hw/rtl/lav_front.sv]
// Front stage: takes a request and forms eye - target.
`default_nettype none
module lav_front import lav_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [2:0][IN_W-1:0] i_eye,
    input  wire logic [2:0][IN_W-1:0] i_target,
    input  wire logic [2:0][IN_W-1:0] i_up,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output t_item                     o_item
);
    logic  r_vld;
    t_item r_item;
    t_item n_item;

    always_comb begin
        n_item.eye = i_eye;
        n_item.up  = i_up;
        for (int k = 0; k < 3; k++) begin
            n_item.dif[k] = D_W'($signed(i_eye[k])) - D_W'($signed(i_target[k]));
        end
    end

    assign o_ready = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_item <= n_item;
        end
    end
endmodule
`default_nettype wire

[hw/rtl/lav_fifo.sv]
// Two-entry request queue between front and back.
`default_nettype none
module lav_fifo import lav_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  t_item     i_item,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_item     o_item
);
    t_item      r_mem [0:1];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       c_push;
    logic       c_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];
    assign c_push  = i_valid && o_ready;
    assign c_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (c_push) r_wp <= !r_wp;
            if (c_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, c_push} - {1'b0, c_pop};
        end
        if (c_push) begin
            r_mem[r_wp] <= i_item;
        end
    end
endmodule
`default_nettype wire

[hw/rtl/lav_norm.sv]
// Vector normalize unit: prescale, sum of squares, bit-serial root, serial divide.
`default_nettype none
module lav_norm import lav_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [2:0][V_W-1:0]  i_v,
    output t_norm_res                 o_res,
    output logic [2:0][AX_W-1:0]      o_axis
);
    typedef enum logic [5:0] {
        N_IDLE  = 6'b000001,
        N_SHIFT = 6'b000010,
        N_SQ    = 6'b000100,
        N_ROOT  = 6'b001000,
        N_LOAD  = 6'b010000,
        N_DIV   = 6'b100000
    } t_nstate;

    t_nstate              r_state;
    logic                 r_done;
    logic                 r_ok;
    logic [2:0][V_W-1:0]  r_w;
    logic [V_W-1:0]       r_mx;
    logic [1:0]           r_idx;
    logic [SQ_W-1:0]      r_sum;
    logic [SQ_W-1:0]      r_n;
    logic [SQ_W-1:0]      r_res;
    logic [SQ_W-1:0]      r_bit;
    logic [MAG_W-1:0]     r_len;
    logic [MAG_W-1:0]     r_rem;
    logic [FRAC_BITS:0]   r_quo;
    logic [DCNT_W-1:0]    r_cnt;
    logic [2:0][AX_W-1:0] r_axis;

    logic [V_W-1:0]   c_abs0, c_abs1, c_abs2, c_mx, c_absw;
    logic [MAG_W-1:0] c_mag;
    logic [SQ_W-1:0]  c_sum_nx, c_trial, c_res_nx;
    logic             c_take;
    logic [NUM_W-1:0] c_num;
    logic [MAG_W:0]   c_rem2;
    logic             c_ge;
    logic [MAG_W:0]   c_rem_nx;
    logic [FRAC_BITS:0] c_quo_nx;
    logic [AX_W-1:0]  c_q;

    function automatic logic [V_W-1:0] abs_v(input logic [V_W-1:0] x);
        abs_v = x[V_W-1] ? (~x + 1'b1) : x;
    endfunction

    always_comb begin
        c_abs0   = abs_v(i_v[0]);
        c_abs1   = abs_v(i_v[1]);
        c_abs2   = abs_v(i_v[2]);
        c_mx     = (c_abs0 > c_abs1) ? c_abs0 : c_abs1;
        c_mx     = (c_abs2 > c_mx) ? c_abs2 : c_mx;
        c_absw   = abs_v(r_w[r_idx]);
        c_mag    = c_absw[MAG_W-1:0];
        c_sum_nx = r_sum + SQ_W'(c_mag * c_mag);
        c_trial  = r_res + r_bit;
        c_take   = (r_n >= c_trial);
        c_res_nx = c_take ? ((r_res >> 1) + r_bit) : (r_res >> 1);
        // rounded numerator: mag * 2^F + len/2
        c_num    = (NUM_W'(c_mag) << FRAC_BITS) + NUM_W'(r_len >> 1);
        c_rem2   = {r_rem, r_quo[FRAC_BITS]};
        c_ge     = (c_rem2 >= {1'b0, r_len});
        c_rem_nx = c_ge ? (c_rem2 - {1'b0, r_len}) : c_rem2;
        c_quo_nx = {r_quo[FRAC_BITS-1:0], c_ge};
        c_q      = {1'b0, c_quo_nx};
    end

    assign o_res.done = r_done;
    assign o_res.ok   = r_ok;
    assign o_axis     = r_axis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= N_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                N_IDLE: begin
                    if (i_start) begin
                        r_state <= N_SHIFT;
                    end
                end
                N_SHIFT: begin
                    if (r_mx < PRE_LIM) begin
                        r_state <= N_SQ;
                    end
                end
                N_SQ: begin
                    if (r_idx == 2'd2) begin
                        r_state <= N_ROOT;
                    end
                end
                N_ROOT: begin
                    if (r_bit[0]) begin
                        if (c_res_nx == '0) begin
                            r_state <= N_IDLE;
                            r_done  <= 1'b1;
                        end else begin
                            r_state <= N_LOAD;
                        end
                    end
                end
                N_LOAD: begin
                    r_state <= N_DIV;
                end
                N_DIV: begin
                    if (r_cnt == DCNT_W'(FRAC_BITS)) begin
                        if (r_idx == 2'd2) begin
                            r_state <= N_IDLE;
                            r_done  <= 1'b1;
                        end else begin
                            r_state <= N_LOAD;
                        end
                    end
                end
                default: r_state <= N_IDLE;
            endcase
        end

        case (r_state)
            N_IDLE: begin
                if (i_start) begin
                    r_w  <= i_v;
                    r_mx <= c_mx;
                end
            end
            N_SHIFT: begin
                if (r_mx >= PRE_LIM) begin
                    r_mx <= r_mx >> 1;
                    for (int k = 0; k < 3; k++) begin
                        r_w[k] <= V_W'($signed(r_w[k]) >>> 1);
                    end
                end else begin
                    r_idx <= 2'd0;
                    r_sum <= '0;
                end
            end
            N_SQ: begin
                r_sum <= c_sum_nx;
                r_idx <= r_idx + 2'd1;
                if (r_idx == 2'd2) begin
                    r_n   <= c_sum_nx;
                    r_res <= '0;
                    r_bit <= SQ_W'(1) << (SQ_W - 2);
                end
            end
            N_ROOT: begin
                if (c_take) begin
                    r_n <= r_n - c_trial;
                end
                r_res <= c_res_nx;
                r_bit <= r_bit >> 2;
                if (r_bit[0]) begin
                    r_len <= c_res_nx[MAG_W-1:0];
                    r_idx <= 2'd0;
                    if (c_res_nx == '0) begin
                        r_ok   <= 1'b0;
                        r_axis <= '0;
                    end
                end
            end
            N_LOAD: begin
                r_rem <= c_num[NUM_W-1:FRAC_BITS+1];
                r_quo <= c_num[FRAC_BITS:0];
                r_cnt <= '0;
            end
            N_DIV: begin
                r_rem <= c_rem_nx[MAG_W-1:0];
                r_quo <= c_quo_nx;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DCNT_W'(FRAC_BITS)) begin
                    r_axis[r_idx] <= r_w[r_idx][V_W-1] ? (AX_W'(0) - c_q) : c_q;
                    r_idx         <= r_idx + 2'd1;
                    r_ok          <= 1'b1;
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

[hw/rtl/lav_back.sv]
// Back end: sequences the three normalizations, cross products, dots and row output.
`default_nettype none
module lav_back import lav_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  t_item                       i_item,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [1:0]                  o_row_index,
    output logic signed [AX_W-1:0]      o_entry_a,
    output logic signed [AX_W-1:0]      o_entry_b,
    output logic signed [AX_W-1:0]      o_entry_c,
    output logic signed [IN_W-1:0]      o_shift_term,
    output logic                        o_last_row,
    output logic                        o_degenerate
);
    typedef enum logic [7:0] {
        B_IDLE = 8'b00000001,
        B_NZ   = 8'b00000010,
        B_CR1  = 8'b00000100,
        B_NX   = 8'b00001000,
        B_CR2  = 8'b00010000,
        B_NY   = 8'b00100000,
        B_DOT  = 8'b01000000,
        B_EMIT = 8'b10000000
    } t_bstate;

    t_bstate                     r_state;
    logic                        r_start;
    logic                        r_ok;
    logic [2:0][IN_W-1:0]        r_eye;
    logic [2:0][IN_W-1:0]        r_up;
    logic [2:0][V_W-1:0]         r_nv;
    logic [2:0][2:0][AX_W-1:0]   r_ax;   // [row][comp]: row 0 x, 1 y, 2 z
    logic [2:0][IN_W-1:0]        r_sh;
    logic [1:0]                  r_c;
    logic [1:0]                  r_k;
    logic [DOT_W-1:0]            r_acc;
    logic                        r_ovld;
    logic [1:0]                  r_row;
    logic [AX_W-1:0]             r_ea, r_eb, r_ec;
    logic [IN_W-1:0]             r_st;
    logic                        r_last;
    logic                        r_deg;

    t_norm_res                   c_nres;
    logic [2:0][AX_W-1:0]        c_naxis;
    logic [2:0][IN_W-1:0]        c_a;
    logic [2:0][AX_W-1:0]        c_b;
    logic [1:0]                  c_j1, c_j2;
    logic signed [V_W-2:0]       c_p1, c_p2;
    logic [V_W-1:0]              c_cr;
    logic signed [DOT_W-3:0]     c_prod;
    logic [DOT_W-1:0]            c_acc;
    logic signed [DOT_W:0]       c_neg;
    logic signed [DOT_W:0]       c_t;
    logic [IN_W-1:0]             c_sat;
    logic                        c_oload;

    lav_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_v     (r_nv),
        .o_res   (c_nres),
        .o_axis  (c_naxis)
    );

    always_comb begin
        case (r_c)
            2'd0:    begin c_j1 = 2'd1; c_j2 = 2'd2; end
            2'd1:    begin c_j1 = 2'd2; c_j2 = 2'd0; end
            2'd2:    begin c_j1 = 2'd0; c_j2 = 2'd1; end
            default: begin c_j1 = 2'd1; c_j2 = 2'd2; end
        endcase
        // first pass: up x z, second pass: z x x
        for (int k = 0; k < 3; k++) begin
            c_a[k] = (r_state == B_CR2) ? IN_W'($signed(r_ax[2][k])) : r_up[k];
            c_b[k] = (r_state == B_CR2) ? r_ax[0][k] : r_ax[2][k];
        end
        c_p1   = $signed(c_a[c_j1]) * $signed(c_b[c_j2]);
        c_p2   = $signed(c_a[c_j2]) * $signed(c_b[c_j1]);
        c_cr   = V_W'(c_p1) - V_W'(c_p2);

        c_prod = $signed(r_ax[r_k][r_c]) * $signed(r_eye[r_c]);
        c_acc  = r_acc + DOT_W'(c_prod);
        // round half up of -dot, then saturate
        c_neg  = (DOT_W+1)'(0) - {c_acc[DOT_W-1], c_acc}
                 + ((DOT_W+1)'(1) << (FRAC_BITS - 1));
        c_t    = c_neg >>> FRAC_BITS;
        if (c_t[DOT_W:IN_W-1] == '0 || c_t[DOT_W:IN_W-1] == '1) begin
            c_sat = c_t[IN_W-1:0];
        end else begin
            c_sat = c_t[DOT_W] ? {1'b1, {(IN_W-1){1'b0}}} : {1'b0, {(IN_W-1){1'b1}}};
        end
        c_oload = !r_ovld || i_ready;
    end

    assign o_ready      = (r_state == B_IDLE);
    assign o_valid      = r_ovld;
    assign o_row_index  = r_row;
    assign o_entry_a    = $signed(r_ea);
    assign o_entry_b    = $signed(r_eb);
    assign o_entry_c    = $signed(r_ec);
    assign o_shift_term = $signed(r_st);
    assign o_last_row   = r_last;
    assign o_degenerate = r_deg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_start <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (i_ready) r_ovld <= 1'b0;
            case (r_state)
                B_IDLE: begin
                    if (i_valid) begin
                        r_state <= B_NZ;
                        r_start <= 1'b1;
                    end
                end
                B_NZ:  if (c_nres.done) r_state <= B_CR1;
                B_CR1: begin
                    if (r_c == 2'd2) begin
                        r_state <= B_NX;
                        r_start <= 1'b1;
                    end
                end
                B_NX:  if (c_nres.done) r_state <= B_CR2;
                B_CR2: begin
                    if (r_c == 2'd2) begin
                        r_state <= B_NY;
                        r_start <= 1'b1;
                    end
                end
                B_NY:  if (c_nres.done) r_state <= B_DOT;
                B_DOT: if (r_c == 2'd2 && r_k == 2'd2) r_state <= B_EMIT;
                B_EMIT: begin
                    if (c_oload) begin
                        r_ovld <= 1'b1;
                        if (r_k == 2'd2) r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end

        case (r_state)
            B_IDLE: begin
                if (i_valid) begin
                    r_eye <= i_item.eye;
                    r_up  <= i_item.up;
                    r_ok  <= 1'b1;
                    for (int k = 0; k < 3; k++) begin
                        r_nv[k] <= V_W'($signed(i_item.dif[k]));
                    end
                end
            end
            B_NZ, B_NX, B_NY: begin
                if (c_nres.done) begin
                    r_ok <= r_ok && c_nres.ok;
                    r_c  <= 2'd0;
                    r_k  <= 2'd0;
                    r_acc <= '0;
                    if (r_state == B_NZ) r_ax[2] <= c_naxis;
                    else if (r_state == B_NX) r_ax[0] <= c_naxis;
                    else r_ax[1] <= c_naxis;
                end
            end
            B_CR1, B_CR2: begin
                r_nv[r_c] <= c_cr;
                r_c       <= r_c + 2'd1;
            end
            B_DOT: begin
                if (r_c == 2'd2) begin
                    r_c       <= 2'd0;
                    r_acc     <= '0;
                    r_sh[r_k] <= c_sat;
                    r_k       <= (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
                end else begin
                    r_c   <= r_c + 2'd1;
                    r_acc <= c_acc;
                end
            end
            B_EMIT: begin
                if (c_oload) begin
                    r_row  <= r_k;
                    r_ea   <= r_ok ? r_ax[r_k][0] : '0;
                    r_eb   <= r_ok ? r_ax[r_k][1] : '0;
                    r_ec   <= r_ok ? r_ax[r_k][2] : '0;
                    r_st   <= r_ok ? r_sh[r_k] : '0;
                    r_last <= (r_k == 2'd2);
                    r_deg  <= !r_ok;
                    r_k    <= r_k + 2'd1;
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

[tb/look_at_view_matrix_tb.sv]
// Self-checking testbench for the look-at view matrix block.
module look_at_view_matrix_tb;
    import lav_pkg::*;

    localparam longint ONE       = 64'sd1 <<< FRAC_BITS;
    localparam int     N_RANDOM  = 118;
    localparam int     CYC_LIMIT = 600000;
    localparam int     LONG_HOLD = 2000;

    typedef struct {
        logic signed [IN_W-1:0] eye[3];
        logic signed [IN_W-1:0] tgt[3];
        logic signed [IN_W-1:0] up[3];
        bit                     drain_first;  // wait for all rows before sending
    } camera_t;

    typedef struct {
        logic [1:0]             row;
        logic signed [AX_W-1:0] a, b, c;
        logic signed [IN_W-1:0] shift;
        logic                   last, degen;
    } row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    logic o_ready, o_valid, o_last_row, o_degenerate;
    logic [1:0] o_row_index;
    logic signed [AX_W-1:0] o_entry_a, o_entry_b, o_entry_c;
    logic signed [IN_W-1:0] o_shift_term;
    logic signed [IN_W-1:0] cam_eye[3] = '{0, 0, 0};
    logic signed [IN_W-1:0] cam_tgt[3] = '{0, 0, 0};
    logic signed [IN_W-1:0] cam_up[3]  = '{0, 0, 0};

    camera_t cam_queue[$];
    row_t    rows_due[$];
    camera_t cur_cam;
    int n_issued = 0, n_taken = 0, n_rows = 0, n_fail = 0, n_degen = 0;
    int send_gap = 0, rx_hold = 0, rx_seen = 0, cycles = 0, n_total = 0;
    bit idle_on = 1'b1, long_req = 1'b0, rst_done = 1'b0;

    look_at_view_matrix DUT (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_eye_x(cam_eye[0]), .i_eye_y(cam_eye[1]), .i_eye_z(cam_eye[2]),
        .i_target_x(cam_tgt[0]), .i_target_y(cam_tgt[1]), .i_target_z(cam_tgt[2]),
        .i_up_x(cam_up[0]), .i_up_y(cam_up[1]), .i_up_z(cam_up[2]),
        .o_valid, .i_ready, .o_row_index, .o_entry_a, .o_entry_b, .o_entry_c,
        .o_shift_term, .o_last_row, .o_degenerate
    );

    always #5 i_clk = ~i_clk;

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res = 0;
        longint unsigned bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint mag64(longint v);
        return v < 0 ? -v : v;
    endfunction

    // Scale-free normalize: prescale below 2^30, floor sqrt, round half away from zero.
    function automatic bit unit_vec(input longint v[3], output longint u[3]);
        longint w[3];
        longint mx = 0, len, q;
        longint unsigned sum = 0;
        int s = 0;
        u = '{0, 0, 0};
        if (v[0] == 0 && v[1] == 0 && v[2] == 0) return 1'b0;
        for (int i = 0; i < 3; i++) if (mag64(v[i]) > mx) mx = mag64(v[i]);
        while (s < 62 && (mx >> s) >= (64'sd1 <<< 30)) s++;
        for (int i = 0; i < 3; i++) begin
            w[i] = v[i] >>> s;
            sum += longint'(w[i] * w[i]);
        end
        len = longint'(int_sqrt(sum));
        if (len == 0) return 1'b0;
        for (int i = 0; i < 3; i++) begin
            q = (mag64(w[i]) * ONE + len / 2) / len;
            u[i] = w[i] < 0 ? -q : q;
        end
        return 1'b1;
    endfunction

    function automatic void cross3(input longint p[3], input longint r[3],
                                   output longint o[3]);
        o[0] = p[1] * r[2] - p[2] * r[1];
        o[1] = p[2] * r[0] - p[0] * r[2];
        o[2] = p[0] * r[1] - p[1] * r[0];
    endfunction

    task automatic predict_rows(input camera_t cam);
        longint e[3], d[3], u[3], tmp[3], ax[3][3], dot, t;
        bit ok;
        row_t r;
        for (int i = 0; i < 3; i++) begin
            e[i] = cam.eye[i];
            u[i] = cam.up[i];
            d[i] = e[i] - longint'(cam.tgt[i]);
        end
        ok = unit_vec(d, ax[2]);
        cross3(u, ax[2], tmp);
        ok = unit_vec(tmp, ax[0]) && ok;
        cross3(ax[2], ax[0], tmp);
        ok = unit_vec(tmp, ax[1]) && ok;
        if (!ok) n_degen++;
        for (int k = 0; k < 3; k++) begin
            dot = ax[k][0] * e[0] + ax[k][1] * e[1] + ax[k][2] * e[2];
            t = (-dot + (ONE >>> 1)) >>> FRAC_BITS;
            if (t > 64'sd2147483647) t = 64'sd2147483647;
            if (t < -64'sd2147483648) t = -64'sd2147483648;
            r.row   = 2'(k);
            r.a     = ok ? AX_W'(ax[k][0]) : '0;
            r.b     = ok ? AX_W'(ax[k][1]) : '0;
            r.c     = ok ? AX_W'(ax[k][2]) : '0;
            r.shift = ok ? IN_W'(t) : '0;
            r.last  = (k == 2);
            r.degen = !ok;
            rows_due.push_back(r);
        end
    endtask

    // Request accepted: predict its three rows.
    always @(posedge i_clk) begin
        cycles++;
        if (i_rst_n && i_valid && o_ready) begin
            predict_rows(cur_cam);
            n_taken++;
        end
        if (cycles > CYC_LIMIT) begin
            $display("look_at_view_matrix_tb failed");
            $finish;
        end
    end

    // Row checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            n_rows++;
            if (rows_due.size() == 0) begin
                $error("unexpected row %0d", o_row_index);
                n_fail++;
            end else begin
                row_t x;
                x = rows_due.pop_front();
                if (o_row_index !== x.row) begin
                    $error("row_index: expected %0d, got %0d", x.row, o_row_index);
                    n_fail++;
                end
                if (o_entry_a !== x.a) begin
                    $error("entry_a: expected %0d, got %0d", x.a, o_entry_a);
                    n_fail++;
                end
                if (o_entry_b !== x.b) begin
                    $error("entry_b: expected %0d, got %0d", x.b, o_entry_b);
                    n_fail++;
                end
                if (o_entry_c !== x.c) begin
                    $error("entry_c: expected %0d, got %0d", x.c, o_entry_c);
                    n_fail++;
                end
                if (o_shift_term !== x.shift) begin
                    $error("shift_term: expected %0d, got %0d", x.shift, o_shift_term);
                    n_fail++;
                end
                if (o_last_row !== x.last) begin
                    $error("last_row: expected %0d, got %0d", x.last, o_last_row);
                    n_fail++;
                end
                if (o_degenerate !== x.degen) begin
                    $error("degenerate: expected %0d, got %0d", x.degen, o_degenerate);
                    n_fail++;
                end
            end
        end
    end

    // Request driver
    always @(negedge i_clk) begin
        if (!rst_done || (i_valid && n_taken != n_issued)) begin
            // hold current request
        end else if (send_gap > 0) begin
            i_valid <= 1'b0;
            send_gap--;
        end else if (cam_queue.size() != 0 &&
                     !(cam_queue[0].drain_first && rows_due.size() != 0)) begin
            cur_cam = cam_queue.pop_front();
            cam_eye <= cur_cam.eye;
            cam_tgt <= cur_cam.tgt;
            cam_up  <= cur_cam.up;
            i_valid <= 1'b1;
            n_issued++;
            send_gap = idle_on ? $urandom_range(0, 3) : 0;
        end else begin
            i_valid <= 1'b0;
        end
    end

    // Row receiver
    always @(negedge i_clk) begin
        if (rst_done) begin
            if (long_req) begin
                rx_hold = LONG_HOLD;
                long_req = 1'b0;
            end else if (n_rows != rx_seen) begin
                rx_seen = n_rows;
                rx_hold = idle_on ? $urandom_range(0, 3) : 0;
            end
            if (rx_hold > 0) begin
                i_ready <= 1'b0;
                rx_hold--;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    task automatic add_cam(input longint ex, ey, ez, tx, ty, tz, ux, uy, uz,
                           input bit drain = 1'b0);
        camera_t c;
        c.eye = '{IN_W'(ex), IN_W'(ey), IN_W'(ez)};
        c.tgt = '{IN_W'(tx), IN_W'(ty), IN_W'(tz)};
        c.up  = '{IN_W'(ux), IN_W'(uy), IN_W'(uz)};
        c.drain_first = drain;
        cam_queue.push_back(c);
        n_total++;
    endtask

    function automatic longint rnd_coord();
        case ($urandom_range(0, 3))
            0: return longint'($signed($urandom));
            1: return -longint'($urandom_range(0, 3)) * ONE;
            default: return longint'($signed($urandom) >>> $urandom_range(4, 24));
        endcase
    endfunction

    initial begin
        longint MX, MN, e[3], t[3], u[3], k;
        MX = 64'sd2147483647;
        MN = -64'sd2147483648;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        rst_done = 1'b1;

        // directed: plain view, degenerate forms, extremes, tiny vectors
        add_cam(0, 0, 5 * ONE, 0, 0, 0, 0, ONE, 0);
        add_cam(ONE, 2 * ONE, 3 * ONE, ONE, 2 * ONE, 3 * ONE, 0, ONE, 0);
        add_cam(0, 0, 5 * ONE, 0, 0, 0, 0, 0, ONE);
        add_cam(0, 0, 5 * ONE, 0, 0, 0, 0, 0, 0);
        add_cam(MX, MX, MX, MN, MN, MN, MX, 0, MN);
        add_cam(MN, MN, MN, MX, MX, MX, MN, MN, MX);
        add_cam(MX, MN, MX, MN, MX, MN, MX, MX, MX);
        add_cam(MN, 0, 0, MX, 0, 0, 0, MN, 0);
        add_cam(1, 0, 0, 0, 0, 0, 0, 1, 0);
        add_cam(0, 0, 1, 0, 0, 0, 1, 0, 0);
        add_cam(3 * ONE, ONE, -2 * ONE, -ONE, ONE, 4 * ONE, 0, -ONE, 0);
        add_cam(MX, MX, MX, MX, MX, MX, ONE, 0, 0);
        add_cam(-1, -1, -1, 0, 0, 0, 1, 1, 1);
        add_cam(MX, 7, -3, -ONE, 5, 9, MX, MN, 1);

        for (int n = 0; n < N_RANDOM; n++) begin
            for (int i = 0; i < 3; i++) begin
                e[i] = rnd_coord();
                t[i] = rnd_coord();
                u[i] = rnd_coord();
            end
            case ($urandom_range(0, 15))
                0: t = e;                                  // eye on target
                1: begin                                   // up along view axis
                    k = $urandom_range(1, 3);
                    for (int i = 0; i < 3; i++) begin
                        e[i] = e[i] >>> 4;
                        t[i] = t[i] >>> 4;
                        u[i] = (e[i] - t[i]) * k;
                        if (u[i] > MX || u[i] < MN) u[i] = e[i] - t[i];
                    end
                end
                default: ;
            endcase
            add_cam(e[0], e[1], e[2], t[0], t[1], t[2], u[0], u[1], u[2], n == 60);
        end

        wait (n_taken >= 40);
        idle_on = 1'b0;
        wait (n_taken >= 70);
        idle_on = 1'b1;
    end

    initial begin
        wait (n_rows >= 30);
        long_req = 1'b1;
    end

    initial begin
        wait (rst_done && n_total > 0);
        wait (cam_queue.size() == 0 && n_taken == n_total && rows_due.size() == 0);
        repeat (500) @(posedge i_clk);
        if (rows_due.size() != 0) begin
            $error("%0d rows never arrived", rows_due.size());
            n_fail++;
        end
        $display("Covered %0d camera setups (%0d degenerate) and checked %0d rows,",
                 n_taken, n_degen, n_rows);
        $display("with random stalls, a long output stall and a drained pause.");
        if (n_fail == 0) begin
            $display("look_at_view_matrix_tb passed");
        end else begin
            $display("look_at_view_matrix_tb failed");
        end
        $finish;
    end
endmodule
